// ===== src/jti_pkg.sv =====
package jti_pkg;

	localparam int POS_FRAC_BITS_DEF = 16;

	// Pi in Q32.32, rounded to nearest; the limit reset is derived from it.
	localparam logic [63:0] PI_Q32 = 64'd13493037705;
	localparam logic [63:0] MASK31 = 64'h0000_0000_7FFF_FFFF;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_CUBIC  = 1'b1;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ZERO_DUR   = 2'd1;
	localparam logic [1:0] STAT_OVER_LIMIT = 2'd2;
	localparam logic [1:0] STAT_BUSY       = 2'd3;

	localparam logic [1:0] REG_LIMIT_ONE   = 2'd0;
	localparam logic [1:0] REG_LIMIT_TWO   = 2'd1;
	localparam logic [1:0] REG_LIMIT_THREE = 2'd2;

	localparam int NUM_JOINTS = 3;
	localparam int SHAPE_BITS = 30;

	// Linear: 51 numerator bits shifted in. Cubic: 31 fraction bits.
	localparam int DIV_STEPS_LIN = 51;
	localparam int DIV_STEPS_CUB = SHAPE_BITS + 1;
	localparam int CNT_W = 6;

	typedef struct packed {
		logic               op;
		logic signed [31:0] goal_one;
		logic signed [31:0] goal_two;
		logic signed [31:0] goal_three;
		logic [15:0]        duration_ticks;
		logic               mode;
	} jti_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] pos_one;
		logic signed [31:0] pos_two;
		logic signed [31:0] pos_three;
		logic               moving;
	} jti_out_t;

	typedef struct packed {
		logic mul1;
		logic mul2;
		logic dinit;
		logic dstep;
		logic fmul;
	} jti_ctl_t;

endpackage

// ===== src/joint_trajectory_interpolator.sv =====
// Channel  Signals                          Moves
// cmd      cmd_valid cmd_ready cmd          one start or tick word
// res      res_valid res_ready res          one status and position word
// cfg      cfg_valid cfg_ready cfg_index    one joint limit write
//          cfg_data
//
// Starts, idle ticks and final ticks give their word in the cycle after acceptance.
// A tick mid-move runs through MUL1, MUL2, DINIT, the one-bit-per-cycle restoring
// divider in each joint lane (longer in linear mode), FMUL and FIN.
// Reset clears all move state and loads the default limits; the limit port
// is always ready. A stalled result word holds, and the next word is taken
// in the cycle that the result is taken.
module joint_trajectory_interpolator #(
	parameter int POS_FRAC_BITS = jti_pkg::POS_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  jti_pkg::jti_in_t cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output jti_pkg::jti_out_t res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [30:0]      cfg_data
);
	import jti_pkg::*;

	localparam logic [63:0] LIM_PI_FULL =
		(PI_Q32 + (64'd1 << (31 - POS_FRAC_BITS))) >> (32 - POS_FRAC_BITS);
	localparam logic [30:0] LIM_PI   = 31'(LIM_PI_FULL & MASK31);
	localparam logic [30:0] LIM_HALF = 31'((64'd1 << (POS_FRAC_BITS - 1)) & MASK31);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_MUL2  = 3'd2;
	localparam logic [2:0] ST_DINIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FMUL  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [30:0]        limit_q [NUM_JOINTS];
	logic signed [31:0] start_q [NUM_JOINTS];
	logic signed [32:0] delta_q [NUM_JOINTS];
	logic signed [31:0] cur_q   [NUM_JOINTS];
	logic [15:0]        len_q;
	logic [15:0]        elapsed_q;
	logic               mode_q;
	logic               busy_q;
	logic               res_valid_q;
	jti_out_t           res_q;

	logic               cmd_fire;
	logic signed [31:0] goal    [NUM_JOINTS];
	logic signed [31:0] goal_pos[NUM_JOINTS];
	logic signed [31:0] lane_pos[NUM_JOINTS];
	logic [NUM_JOINTS-1:0] over;
	logic [1:0]         stat;
	logic [15:0]        e_nx;
	jti_ctl_t           ctl;
	logic [47:0]        shape_num;
	logic [47:0]        shape_den;

	assign goal[0] = cmd.goal_one;
	assign goal[1] = cmd.goal_two;
	assign goal[2] = cmd.goal_three;

	assign cmd_ready = (state_q == ST_IDLE) && (!res_valid_q || res_ready);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign e_nx      = elapsed_q + 16'd1;

	always_comb begin
		for (int j = 0; j < NUM_JOINTS; j++) begin
			over[j] = (goal[j][31] ? 32'(-goal[j]) : 32'(goal[j])) > {1'b0, limit_q[j]};
			goal_pos[j] = 32'(delta_q[j] + 33'(start_q[j]));
		end
		priority if (cmd.duration_ticks == 16'd0) begin
			stat = STAT_ZERO_DUR;
		end else if (|over) begin
			stat = STAT_OVER_LIMIT;
		end else if (busy_q) begin
			stat = STAT_BUSY;
		end else begin
			stat = STAT_OK;
		end
		ctl.mul1  = state_q == ST_MUL1;
		ctl.mul2  = state_q == ST_MUL2;
		ctl.dinit = state_q == ST_DINIT;
		ctl.dstep = state_q == ST_DIV;
		ctl.fmul  = state_q == ST_FMUL;
	end

	jti_shape u_shape (
		.clk       (clk),
		.ctl       (ctl),
		.elapsed   (elapsed_q),
		.len       (len_q),
		.shape_num (shape_num),
		.shape_den (shape_den)
	);

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
		jti_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.mode      (mode_q),
			.delta     (delta_q[j]),
			.start_pos (start_q[j]),
			.elapsed   (elapsed_q),
			.len       (len_q),
			.shape_num (shape_num),
			.shape_den (shape_den),
			.pos       (lane_pos[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			limit_q[0]  <= LIM_PI;
			limit_q[1]  <= LIM_PI;
			limit_q[2]  <= LIM_HALF;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				start_q[j] <= '0;
				delta_q[j] <= '0;
				cur_q[j]   <= '0;
			end
			len_q       <= '0;
			elapsed_q   <= '0;
			mode_q      <= MODE_LINEAR;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LIMIT_ONE:   limit_q[0] <= cfg_data;
					REG_LIMIT_TWO:   limit_q[1] <= cfg_data;
					REG_LIMIT_THREE: limit_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.op == OP_START) begin
							if (stat == STAT_OK) begin
								for (int j = 0; j < NUM_JOINTS; j++) begin
									start_q[j] <= cur_q[j];
									delta_q[j] <= 33'(goal[j]) - 33'(cur_q[j]);
								end
								len_q     <= cmd.duration_ticks;
								elapsed_q <= '0;
								mode_q    <= cmd.mode;
								busy_q    <= 1'b1;
							end
							res_q       <= '{stat, cur_q[0], cur_q[1], cur_q[2],
								busy_q || (stat == STAT_OK)};
							res_valid_q <= 1'b1;
						end else if (busy_q) begin
							elapsed_q <= e_nx;
							if (e_nx >= len_q) begin
								// The move ends on the goal exactly.
								for (int j = 0; j < NUM_JOINTS; j++) begin
									cur_q[j] <= goal_pos[j];
								end
								busy_q      <= 1'b0;
								res_q       <= '{STAT_OK, goal_pos[0], goal_pos[1],
									goal_pos[2], 1'b0};
								res_valid_q <= 1'b1;
							end else begin
								state_q <= ST_MUL1;
							end
						end else begin
							res_q       <= '{STAT_OK, cur_q[0], cur_q[1], cur_q[2], 1'b0};
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DINIT;
				ST_DINIT: begin
					cnt_q   <= (mode_q == MODE_CUBIC) ? CNT_W'(DIV_STEPS_CUB - 1)
						: CNT_W'(DIV_STEPS_LIN - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FMUL;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_FMUL: state_q <= ST_FIN;
				ST_FIN: begin
					for (int j = 0; j < NUM_JOINTS; j++) begin
						cur_q[j] <= lane_pos[j];
					end
					res_q       <= '{STAT_OK, lane_pos[0], lane_pos[1], lane_pos[2], 1'b1};
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/jti_shape.sv =====
module jti_shape (
	input  logic             clk,
	input  jti_pkg::jti_ctl_t ctl,
	input  logic [15:0]      elapsed,
	input  logic [15:0]      len,
	output logic [47:0]      shape_num,
	output logic [47:0]      shape_den
);
	import jti_pkg::*;

	logic [31:0] t2_s1;
	logic [31:0] e2_s1;
	logic [17:0] w_s1;
	logic [47:0] num_s2;
	logic [47:0] den_s2;
	logic [49:0] num_full;

	// e^2 * (3T - 2e) stays below T^3 because e < T.
	assign num_full = e2_s1 * w_s1;

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			t2_s1 <= len * len;
			e2_s1 <= elapsed * elapsed;
			w_s1  <= 18'({2'b00, len} + {1'b0, len, 1'b0}) - 18'({elapsed, 1'b0});
		end
		if (ctl.mul2) begin
			den_s2 <= t2_s1 * len;
			num_s2 <= num_full[47:0];
		end
	end

	assign shape_num = num_s2;
	assign shape_den = den_s2;

endmodule

// ===== src/jti_lane.sv =====
module jti_lane (
	input  logic               clk,
	input  jti_pkg::jti_ctl_t  ctl,
	input  logic               mode,
	input  logic signed [32:0] delta,
	input  logic signed [31:0] start_pos,
	input  logic [15:0]        elapsed,
	input  logic [15:0]        len,
	input  logic [47:0]        shape_num,
	input  logic [47:0]        shape_den,
	output logic signed [31:0] pos
);
	import jti_pkg::*;

	logic [32:0] mag_s1;
	logic [48:0] me_s2;
	logic [47:0] rem_q;
	logic [50:0] shin_q;
	logic [47:0] dvs_q;
	logic [33:0] quo_q;
	logic [63:0] prod_q;

	logic [32:0] mag;
	logic [48:0] rem2;
	logic        ge;
	logic [30:0] qs;
	logic [63:0] rnd;
	logic [32:0] off;
	logic [33:0] base;
	logic [33:0] sum;

	assign mag  = delta[32] ? 33'(-delta) : 33'(delta);
	assign rem2 = {rem_q, shin_q[50]};
	assign ge   = rem2 >= {1'b0, dvs_q};
	assign qs   = 31'((35'(quo_q) + 35'd1) >> 1);
	assign rnd  = prod_q + (64'd1 << (SHAPE_BITS - 1));

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			mag_s1 <= mag;
		end
		if (ctl.mul2) begin
			me_s2 <= mag_s1 * elapsed;
		end
		if (ctl.dinit) begin
			quo_q <= '0;
			if (mode == MODE_CUBIC) begin
				rem_q  <= shape_num;
				shin_q <= '0;
				dvs_q  <= shape_den;
			end else begin
				// Rounded quotient: (2*|dx|*e + T) / (2T).
				rem_q  <= '0;
				shin_q <= 51'({me_s2, 1'b0}) + 51'(len);
				dvs_q  <= 48'({len, 1'b0});
			end
		end
		if (ctl.dstep) begin
			rem_q  <= ge ? 48'(rem2 - {1'b0, dvs_q}) : rem2[47:0];
			shin_q <= {shin_q[49:0], 1'b0};
			quo_q  <= {quo_q[32:0], ge};
		end
		if (ctl.fmul) begin
			prod_q <= mag_s1 * qs;
		end
	end

	always_comb begin
		if (mode == MODE_CUBIC) begin
			off = rnd[SHAPE_BITS +: 33];
		end else begin
			off = quo_q[32:0];
		end
		base = {{2{start_pos[31]}}, start_pos};
		sum  = delta[32] ? base - {1'b0, off} : base + {1'b0, off};
	end

	assign pos = sum[31:0];

endmodule
